// File: rtl/core/slotted_ring_opportunistic_insert_unit_assert.svh
// Assertion macros shared by the slotted ring insert unit RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef SLOTTED_RING_OPPORTUNISTIC_INSERT_UNIT_ASSERT_SVH
`define SLOTTED_RING_OPPORTUNISTIC_INSERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SRG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("srg: property violated");
// Condition that must never be true outside reset.
`define SRG_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("srg: forbidden condition seen");
`else
`define SRG_ASSERT(lbl, clk, rst_n, prop)
`define SRG_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/srg_pkg.sv
// Shared types and constants of the slotted ring insert unit.
// Depends on nothing; used by srg_ring and the top level.
package srg_pkg;

	// Largest ring address width and owner field width over the supported slot range.
	localparam int RING_AW = 10;
	localparam int OWN_W   = 4;

	localparam logic [7:0] HOLDOFF_RESET = 8'd10;

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Requests from the tick sequencer to the ring memory.
	typedef struct packed {
		logic               rd_en;
		logic [RING_AW-1:0] rd_addr;
		logic               wr_en;
		logic [RING_AW-1:0] wr_addr;
		logic               wr_valid;
		logic [OWN_W-1:0]   wr_owner;
		logic               scan_start;
	} ring_req_t;

	// Status returned by the ring memory.
	typedef struct packed {
		logic             busy;
		logic             scan_done;
		logic             rd_valid;
		logic [OWN_W-1:0] rd_owner;
		logic [7:0]       occ;
		logic [7:0]       train;
	} ring_sts_t;

	// One result item without its last flag.
	typedef struct packed {
		logic        kind;
		logic [3:0]  station;
		logic [31:0] wait_delay;
		logic [7:0]  occ;
		logic [7:0]  train;
		logic [9:0]  dropped;
	} res_t;

endpackage

// File: rtl/core/srg_ring.sv
// Ring slot memory with its clearing pass and the occupancy / run-length scan.
// Depends on srg_pkg for the request and status structs.
`include "slotted_ring_opportunistic_insert_unit_assert.svh"
module srg_ring import srg_pkg::*; #(
	parameter int RING_SLOTS = 150
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_req_t req,
	output ring_sts_t sts
);

	localparam int AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int CW = $clog2(RING_SLOTS + 1);

	// Each entry holds {valid, owner}.
	logic [OWN_W:0] mem [RING_SLOTS];
	logic [OWN_W:0] rdata_q;

	logic          clr_busy_q;
	logic [AW-1:0] clr_idx_q;
	logic          scan_busy_q;
	logic [AW-1:0] scan_idx_q;
	logic          rv_s1;
	logic          rlast_s1;
	logic          fin_s2;
	logic          done_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] run_q;
	logic [CW-1:0] best_q;
	logic [CW-1:0] lead_q;
	logic          in_lead_q;
	logic [CW-1:0] train_q;

	logic           we;
	logic [AW-1:0]  wa;
	logic [OWN_W:0] wd;
	logic           re;
	logic [AW-1:0]  ra;
	logic [CW-1:0]  run_inc;
	logic [CW:0]    wrap_sum;

	// Port selection: the clearing pass owns the write port, the scan the read port.
	always_comb begin
		we = clr_busy_q | req.wr_en;
		wa = clr_busy_q ? clr_idx_q : req.wr_addr[AW-1:0];
		wd = clr_busy_q ? '0 : {req.wr_valid, req.wr_owner};
		re = scan_busy_q | req.rd_en;
		ra = scan_busy_q ? scan_idx_q : req.rd_addr[AW-1:0];
	end

	// Synchronous memory with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	// Clearing pass after reset, one slot per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(RING_SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign run_inc  = run_q + CW'(1);
	assign wrap_sum = (CW+1)'(lead_q) + (CW+1)'(run_q);

	// Scan over all slots in storage order; a circular run does not depend on rotation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_busy_q <= 1'b0;
			scan_idx_q  <= '0;
			rv_s1       <= 1'b0;
			rlast_s1    <= 1'b0;
			fin_s2      <= 1'b0;
			done_q      <= 1'b0;
			occ_q       <= '0;
			run_q       <= '0;
			best_q      <= '0;
			lead_q      <= '0;
			in_lead_q   <= 1'b1;
			train_q     <= '0;
		end else begin
			rv_s1    <= scan_busy_q;
			rlast_s1 <= scan_busy_q && (scan_idx_q == AW'(RING_SLOTS - 1));
			fin_s2   <= rv_s1 && rlast_s1;
			done_q   <= fin_s2;
			if (req.scan_start) begin
				scan_busy_q <= 1'b1;
				scan_idx_q  <= '0;
				occ_q       <= '0;
				run_q       <= '0;
				best_q      <= '0;
				lead_q      <= '0;
				in_lead_q   <= 1'b1;
			end else if (scan_busy_q) begin
				scan_idx_q <= scan_idx_q + AW'(1);
				if (scan_idx_q == AW'(RING_SLOTS - 1)) begin
					scan_busy_q <= 1'b0;
				end
			end
			if (rv_s1) begin
				if (rdata_q[OWN_W]) begin
					occ_q <= occ_q + CW'(1);
					run_q <= run_inc;
					if (run_inc > best_q) begin
						best_q <= run_inc;
					end
					if (in_lead_q) begin
						lead_q <= lead_q + CW'(1);
					end
				end else begin
					run_q     <= '0;
					in_lead_q <= 1'b0;
				end
			end
			// Close the circle: a run may wrap from the last slot into the first.
			if (fin_s2) begin
				if (in_lead_q) begin
					train_q <= CW'(RING_SLOTS);
				end else if (wrap_sum > (CW+1)'(best_q)) begin
					train_q <= CW'(wrap_sum);
				end else begin
					train_q <= best_q;
				end
			end
		end
	end

	// Status, with counts saturated to eight bits.
	always_comb begin
		sts.busy      = clr_busy_q;
		sts.scan_done = done_q;
		sts.rd_valid  = rdata_q[OWN_W];
		sts.rd_owner  = rdata_q[OWN_W-1:0];
		sts.occ       = (16'(occ_q) > 16'd255) ? 8'hFF : 8'(occ_q);
		sts.train     = (16'(train_q) > 16'd255) ? 8'hFF : 8'(train_q);
	end

	`SRG_NEVER(a_clear_and_scan, clk, arst_n, clr_busy_q && scan_busy_q)
	`SRG_NEVER(a_read_clash, clk, arst_n, scan_busy_q && req.rd_en)
	`SRG_ASSERT(a_train_le_occ, clk, arst_n, done_q |-> (train_q <= occ_q))

endmodule

// File: rtl/core/slotted_ring_opportunistic_insert_unit.sv
// Top level of the slotted ring insert unit: tick sequencer, station queues
// and arrival stamp memory. Depends on srg_pkg and srg_ring.
//
// Usage:
// - Input channel (in_valid/in_ready, arrival_flags): one request is one ring
//   tick; bit s marks a new packet for station s.
// - Output channel (out_valid/out_ready): each tick yields a summary (kind 1)
//   followed by one insert report (kind 0) per station that inserted; last
//   marks the final result of the tick.
// - Configuration channel (cfg_valid/cfg_ready, holdoff_period): always ready;
//   write it only while no tick is in progress.
// - A tick runs the slot scan, which reads the ring memory's single read port
//   one slot per cycle, then an arrival step for each station and then a
//   read/decide pair for each station.
// - The summary is held until the first insert or the end of the tick; a new
//   tick request is taken once the previous tick's last result sits in the
//   output register.
// - After reset the ring memory is cleared slot by slot, during which in_ready
//   stays low. A stalled receiver holds the sequencer in place.
`include "slotted_ring_opportunistic_insert_unit_assert.svh"
module slotted_ring_opportunistic_insert_unit import srg_pkg::*; #(
	parameter int RING_SLOTS   = 150,
	parameter int NUM_STATIONS = 10,
	parameter int QUEUE_DEPTH  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [9:0]  arrival_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [3:0]  station,
	output logic [31:0] wait_delay,
	output logic [7:0]  occupied_slots,
	output logic [7:0]  longest_train,
	output logic [9:0]  dropped_flags,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  holdoff_period
);

	localparam int AW          = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int SW          = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
	localparam int QW          = $clog2(QUEUE_DEPTH);
	localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
	localparam int SPACING     = RING_SLOTS / NUM_STATIONS;
	localparam int STAMP_DEPTH = NUM_STATIONS * (2 ** QW);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_ARRIVE = 6'b000100,
		S_RD     = 6'b001000,
		S_DEC    = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t          state_q;
	logic [SW-1:0]   sidx_q;
	logic [9:0]      flags_q;
	logic [9:0]      dropped_q;
	logic [AW-1:0]   rot_q;
	logic [31:0]     tick_q;
	logic [7:0]      period_q;
	logic [QW-1:0]   head_q  [NUM_STATIONS];
	logic [QW-1:0]   tail_q  [NUM_STATIONS];
	logic [QCW-1:0]  count_q [NUM_STATIONS];
	logic [7:0]      hold_q  [NUM_STATIONS];
	logic [31:0]     stamp_mem [STAMP_DEPTH];
	logic [31:0]     stamp_rd_q;
	res_t            pend_q;
	logic            pend_valid_q;
	res_t            out_q;
	logic            out_last_q;
	logic            out_valid_q;

	ring_req_t       ring_req;
	ring_sts_t       ring_sts;

	logic            out_free;
	logic            out_load;
	logic            last_station;
	logic [AW:0]     place_w;
	logic [AW:0]     phys_sum;
	logic [AW-1:0]   phys;
	logic [AW+4:0]   own_place;
	logic            q_full;
	logic            do_drop;
	logic            do_push;
	logic [9:0]      dropped_nx;
	logic            do_clear;
	logic            do_ins;
	logic            dec_adv;
	logic            stamp_we;
	logic [SW+QW-1:0] stamp_wa;
	logic [SW+QW-1:0] stamp_ra;
	res_t            summary;
	res_t            report;

	srg_ring #(
		.RING_SLOTS(RING_SLOTS)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ring_req),
		.sts   (ring_sts)
	);

	assign out_free     = !out_valid_q || out_ready;
	assign last_station = (sidx_q == SW'(NUM_STATIONS - 1));

	// Storage address of the slot in front of the current station.
	always_comb begin
		place_w   = (AW+1)'(SPACING) * (AW+1)'(sidx_q);
		phys_sum  = place_w + (AW+1)'(RING_SLOTS) - (AW+1)'(rot_q);
		phys      = (phys_sum >= (AW+1)'(RING_SLOTS)) ?
			AW'(phys_sum - (AW+1)'(RING_SLOTS)) : AW'(phys_sum);
		own_place = (AW+5)'(SPACING) * (AW+5)'(ring_sts.rd_owner);
	end

	// Arrival handling and the per-station decision.
	always_comb begin
		q_full     = (count_q[sidx_q] == QCW'(QUEUE_DEPTH));
		do_drop    = flags_q[sidx_q] && q_full;
		do_push    = flags_q[sidx_q] && !q_full;
		dropped_nx = dropped_q | (do_drop ? (10'd1 << sidx_q) : 10'd0);
		do_clear   = ring_sts.rd_valid && (own_place == (AW+5)'(place_w));
		do_ins     = !ring_sts.rd_valid && (hold_q[sidx_q] == 8'd0) &&
			(count_q[sidx_q] != '0);
		dec_adv    = !do_ins || out_free;
		stamp_we   = (state_q == S_ARRIVE) && do_push;
		stamp_wa   = {sidx_q, tail_q[sidx_q]};
		stamp_ra   = {sidx_q, head_q[sidx_q]};
	end

	// The output register takes a new result on an insert or at the end of a tick.
	assign out_load = ((state_q == S_DEC) && do_ins && out_free) ||
		((state_q == S_FIN) && out_free);

	// Result items built from the current state.
	always_comb begin
		summary.kind       = KIND_SUMMARY;
		summary.station    = 4'd0;
		summary.wait_delay = 32'd0;
		summary.occ        = ring_sts.occ;
		summary.train      = ring_sts.train;
		summary.dropped    = dropped_nx;
		report.kind        = KIND_INSERT;
		report.station     = 4'(sidx_q);
		report.wait_delay  = tick_q - stamp_rd_q;
		report.occ         = 8'd0;
		report.train       = 8'd0;
		report.dropped     = 10'd0;
	end

	// Ring requests.
	always_comb begin
		ring_req.rd_en      = (state_q == S_RD);
		ring_req.rd_addr    = RING_AW'(phys);
		ring_req.wr_en      = (state_q == S_DEC) && (do_clear || (do_ins && out_free));
		ring_req.wr_addr    = RING_AW'(phys);
		ring_req.wr_valid   = !do_clear;
		ring_req.wr_owner   = OWN_W'(sidx_q);
		ring_req.scan_start = in_valid && in_ready;
	end

	// Arrival stamp memory.
	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[stamp_wa] <= tick_q;
		end
		if (state_q == S_RD) begin
			stamp_rd_q <= stamp_mem[stamp_ra];
		end
	end

	// Holdoff register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= HOLDOFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= holdoff_period;
		end
	end

	// Tick sequencer with queue pointers and holdoffs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sidx_q       <= '0;
			flags_q      <= '0;
			dropped_q    <= '0;
			rot_q        <= '0;
			tick_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_last_q   <= 1'b0;
			for (int s = 0; s < NUM_STATIONS; s++) begin
				head_q[s]  <= '0;
				tail_q[s]  <= '0;
				count_q[s] <= '0;
				hold_q[s]  <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						flags_q   <= arrival_flags;
						dropped_q <= '0;
						sidx_q    <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ring_sts.scan_done) begin
						state_q <= S_ARRIVE;
					end
				end
				S_ARRIVE: begin
					dropped_q <= dropped_nx;
					if (do_push) begin
						tail_q[sidx_q]  <= (tail_q[sidx_q] == QW'(QUEUE_DEPTH - 1)) ?
							'0 : tail_q[sidx_q] + QW'(1);
						count_q[sidx_q] <= count_q[sidx_q] + QCW'(1);
					end
					if (last_station) begin
						pend_q       <= summary;
						pend_valid_q <= 1'b1;
						sidx_q       <= '0;
						state_q      <= S_RD;
					end else begin
						sidx_q <= sidx_q + SW'(1);
					end
				end
				S_RD: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (!do_clear && do_ins && out_free) begin
						hold_q[sidx_q]  <= period_q;
						head_q[sidx_q]  <= (head_q[sidx_q] == QW'(QUEUE_DEPTH - 1)) ?
							'0 : head_q[sidx_q] + QW'(1);
						count_q[sidx_q] <= count_q[sidx_q] - QCW'(1);
						out_q           <= pend_q;
						out_last_q      <= 1'b0;
						pend_q          <= report;
					end
					if (do_clear || dec_adv) begin
						if (last_station) begin
							state_q <= S_FIN;
						end else begin
							sidx_q  <= sidx_q + SW'(1);
							state_q <= S_RD;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_q        <= pend_q;
						out_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						rot_q        <= (rot_q == AW'(RING_SLOTS - 1)) ? '0 : rot_q + AW'(1);
						tick_q       <= tick_q + 32'd1;
						for (int s = 0; s < NUM_STATIONS; s++) begin
							if (hold_q[s] != 8'd0) begin
								hold_q[s] <= hold_q[s] - 8'd1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Ports.
	assign in_ready       = (state_q == S_IDLE) && !ring_sts.busy;
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign station        = out_q.station;
	assign wait_delay     = out_q.wait_delay;
	assign occupied_slots = out_q.occ;
	assign longest_train  = out_q.train;
	assign dropped_flags  = out_q.dropped;
	assign last           = out_last_q;

	`SRG_NEVER(a_ready_with_pend, clk, arst_n, in_ready && pend_valid_q)
	`SRG_NEVER(a_ring_wr_outside, clk, arst_n, ring_req.wr_en && (state_q != S_DEC))
	`SRG_ASSERT(a_tick_step, clk, arst_n, (state_q == S_FIN && out_free) |=> (tick_q == $past(tick_q) + 32'd1))

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the slotted ring insert unit: a tick driver, a
// result monitor and a tick-level predictor of the ring, the queues and holdoffs.
// Depends on srg_pkg and the RTL of slotted_ring_opportunistic_insert_unit.
module tb_top;
	import srg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_N    = 150;
	localparam int STATION_N = 10;
	localparam int Q_DEPTH   = 1024;
	localparam int SPACING   = RING_N / STATION_N;
	localparam int CYCLE_CAP = 4000000;

	// One result of a tick, with its last flag.
	typedef struct packed {
		res_t body;
		logic last;
	} tick_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [9:0]  arrival_flags;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [3:0]  station;
	logic [31:0] wait_delay;
	logic [7:0]  occupied_slots;
	logic [7:0]  longest_train;
	logic [9:0]  dropped_flags;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  holdoff_period;

	slotted_ring_opportunistic_insert_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.arrival_flags  (arrival_flags),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.station        (station),
		.wait_delay     (wait_delay),
		.occupied_slots (occupied_slots),
		.longest_train  (longest_train),
		.dropped_flags  (dropped_flags),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.holdoff_period (holdoff_period)
	);

	// Predictor state.
	logic             ring_busy [RING_N];
	logic [3:0]       ring_owner [RING_N];
	logic [31:0]      stamp_q [STATION_N][$];
	logic [7:0]       holdoff_left [STATION_N];
	logic [31:0]      tick_no;
	logic [7:0]       period_now;

	logic [9:0]       pending_ticks [$];
	tick_result_t     expected_results [$];
	int               sender_idle_pct;
	int               receiver_idle_pct;
	int               error_count;
	int               cycle_no;

	// Longest circular run of occupied slots.
	function automatic int longest_run();
		int best;
		int run;
		int lead;
		bit in_lead;
		best = 0;
		run = 0;
		lead = 0;
		in_lead = 1;
		for (int i = 0; i < RING_N; i++) begin
			if (ring_busy[i]) begin
				run++;
				if (run > best)
					best = run;
				if (in_lead)
					lead++;
			end else begin
				run = 0;
				in_lead = 0;
			end
		end
		if (in_lead)
			return RING_N;
		if (lead + run > best)
			best = lead + run;
		return best;
	endfunction

	// Advances the ring model by one tick and queues the results it causes.
	function automatic void predict_tick(input logic [9:0] flags);
		int occ;
		int train;
		int p;
		logic [9:0] dropped;
		tick_result_t res;
		tick_result_t batch [$];
		logic keep_busy;
		logic [3:0] keep_owner;
		occ = 0;
		dropped = '0;
		for (int i = 0; i < RING_N; i++)
			if (ring_busy[i])
				occ++;
		for (int s = 0; s < STATION_N; s++) begin
			if (flags[s]) begin
				if (stamp_q[s].size() >= Q_DEPTH)
					dropped[s] = 1'b1;
				else
					stamp_q[s].push_back(tick_no);
			end
		end
		train = longest_run();
		res = '0;
		res.body.kind = KIND_SUMMARY;
		res.body.occ = (occ > 255) ? 8'd255 : 8'(occ);
		res.body.train = (train > 255) ? 8'd255 : 8'(train);
		res.body.dropped = dropped;
		batch.push_back(res);

		// Each station either takes back its own packet or tries to insert.
		for (int s = 0; s < STATION_N; s++) begin
			p = (SPACING * s) % RING_N;
			if (ring_busy[p] && ((SPACING * (ring_owner[p] % STATION_N)) % RING_N) == p) begin
				ring_busy[p] = 1'b0;
				ring_owner[p] = '0;
			end else if (!ring_busy[p] && holdoff_left[s] == 0 && stamp_q[s].size() > 0) begin
				ring_busy[p] = 1'b1;
				ring_owner[p] = 4'(s);
				holdoff_left[s] = period_now;
				res = '0;
				res.body.kind = KIND_INSERT;
				res.body.station = 4'(s);
				res.body.wait_delay = tick_no - stamp_q[s].pop_front();
				batch.push_back(res);
			end
		end
		batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			expected_results.push_back(batch[i]);

		for (int s = 0; s < STATION_N; s++)
			if (holdoff_left[s] != 0)
				holdoff_left[s]--;

		// Rotate the ring by one slot.
		keep_busy = ring_busy[RING_N-1];
		keep_owner = ring_owner[RING_N-1];
		for (int i = RING_N - 1; i > 0; i--) begin
			ring_busy[i] = ring_busy[i-1];
			ring_owner[i] = ring_owner[i-1];
		end
		ring_busy[0] = keep_busy;
		ring_owner[0] = keep_owner;
		tick_no++;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Tick request driver.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (in_valid)
				predict_tick(arrival_flags);
			if (pending_ticks.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				arrival_flags <= pending_ticks.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d station %0d", kind, station);
					error_count++;
				end else begin
					tick_result_t want;
					want = expected_results.pop_front();
					if (kind !== want.body.kind) begin
						$error("kind: expected %0d, got %0d", want.body.kind, kind);
						error_count++;
					end
					if (station !== want.body.station) begin
						$error("station: expected %0d, got %0d", want.body.station, station);
						error_count++;
					end
					if (wait_delay !== want.body.wait_delay) begin
						$error("wait_delay: expected %0d, got %0d",
							want.body.wait_delay, wait_delay);
						error_count++;
					end
					if (occupied_slots !== want.body.occ) begin
						$error("occupied_slots: expected %0d, got %0d",
							want.body.occ, occupied_slots);
						error_count++;
					end
					if (longest_train !== want.body.train) begin
						$error("longest_train: expected %0d, got %0d",
							want.body.train, longest_train);
						error_count++;
					end
					if (dropped_flags !== want.body.dropped) begin
						$error("dropped_flags: expected %h, got %h",
							want.body.dropped, dropped_flags);
						error_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						error_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= CYCLE_CAP) begin
			$display("slotted_ring_opportunistic_insert_unit test failed");
			$finish;
		end
	end

	// Holds off new ticks until every queued tick has been taken and answered.
	task automatic drain_ticks();
		@(posedge clk);
		while (pending_ticks.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	// Writes the holdoff period while the block is idle.
	task automatic write_holdoff(input logic [7:0] value);
		cfg_valid <= 1'b1;
		holdoff_period <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		period_now = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random_ticks(input int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: pending_ticks.push_back(10'(1 << $urandom_range(9)));
				1: pending_ticks.push_back(10'($urandom_range(1023)) & 10'($urandom_range(1023)));
				2: pending_ticks.push_back('0);
				default: pending_ticks.push_back(10'($urandom_range(1023)));
			endcase
		end
	endtask

	// Stimulus sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		arrival_flags = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		holdoff_period = HOLDOFF_RESET;
		cycle_no = 0;
		error_count = 0;
		tick_no = '0;
		period_now = HOLDOFF_RESET;
		sender_idle_pct = 28;
		receiver_idle_pct = 70;
		for (int i = 0; i < RING_N; i++) begin
			ring_busy[i] = 1'b0;
			ring_owner[i] = '0;
		end
		for (int s = 0; s < STATION_N; s++)
			holdoff_left[s] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset holdoff: extremes, single stations and
		// same-tick arrival and insertion.
		pending_ticks.push_back(10'h000);
		pending_ticks.push_back(10'h3FF);
		for (int s = 0; s < STATION_N; s++)
			pending_ticks.push_back(10'(1 << s));
		pending_ticks.push_back(10'h155);
		pending_ticks.push_back(10'h2AA);
		pending_ticks.push_back(10'h3FF);
		pending_ticks.push_back(10'h000);
		drain_ticks();

		// Holdoff zero: stations may insert on every tick, the ring fills up.
		write_holdoff(8'd0);
		queue_random_ticks(150);
		drain_ticks();

		// Longest holdoff with every station receiving a packet on every tick.
		write_holdoff(8'd255);
		for (int i = 0; i < 120; i++)
			pending_ticks.push_back(10'h3FF);
		drain_ticks();

		// Middle settings with the idling the other way round.
		sender_idle_pct = 70;
		receiver_idle_pct = 28;
		write_holdoff(8'd1);
		queue_random_ticks(80);
		drain_ticks();
		write_holdoff(8'($urandom_range(2, 254)));
		queue_random_ticks(60);
		drain_ticks();

		// Back to the reset value with neither side idling.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_holdoff(HOLDOFF_RESET);
		queue_random_ticks(54);
		drain_ticks();
		repeat (300) @(posedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("slotted_ring_opportunistic_insert_unit test passed");
		else
			$display("slotted_ring_opportunistic_insert_unit test failed");
		$finish;
	end
endmodule

// File: files.f
+incdir+rtl/core
rtl/core/srg_pkg.sv
rtl/core/srg_ring.sv
rtl/core/slotted_ring_opportunistic_insert_unit.sv
dv/tb_top.sv
